### hw/rtl/icp_pkg.sv
package icp_pkg;

  // fixed field widths
  localparam int unsigned TIME_W   = 11;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned COLUMN_W = 5;
  localparam int unsigned CCOUNT_W = 6;

  // default capacity of one day
  localparam int unsigned MAX_ITEMS_DEF = 32;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_EMIT_RD  = 6'b000010,
    ST_EMIT_OUT = 6'b000100,
    ST_SRCH_RD  = 6'b001000,
    ST_SRCH_CMP = 6'b010000,
    ST_PLACE    = 6'b100000
  } icp_state_e;

endpackage

### hw/rtl/icp_ram.sv
module icp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/icp_cmp.sv
module icp_cmp (
  input  logic [icp_pkg::TIME_W-1:0] a_i,
  input  logic [icp_pkg::TIME_W-1:0] b_i,
  output logic                       le_o
);
  import icp_pkg::*;

  // shared unsigned compare, a <= b
  assign le_o = (a_i <= b_i);

endmodule

### hw/rtl/interval_column_packing_unit.sv
// channel  | direction | beat fields                                   | handshake
// ---------+-----------+-----------------------------------------------+----------------------
// input    | in        | start_min_i, end_min_i, final_item_i          | in_valid_i / in_stall_o
// result   | out       | item_index_o, column_o, cluster_columns_o,    | out_valid_o / out_stall_i
//          |           | last_of_run_o                                 |
//
// one beat: accepted in idle, then per column probed an end-time read then a compare,
// a further search step when no column is free and a new one opens, a place step, and per result
// beat emitted a member-column read then an output load; past capacity, the accept step plus any flush
// the input stalls from acceptance until the sequencer is back in idle
// a stalled result beat holds in the output register; the sequencer waits on it
// reset clears the day counters; the two column memories need no clearing
module interval_column_packing_unit #(
  parameter int unsigned MAX_ITEMS = icp_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [icp_pkg::TIME_W-1:0]   start_min_i,
  input  logic [icp_pkg::TIME_W-1:0]   end_min_i,
  input  logic                         final_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [icp_pkg::INDEX_W-1:0]  item_index_o,
  output logic [icp_pkg::COLUMN_W-1:0] column_o,
  output logic [icp_pkg::CCOUNT_W-1:0] cluster_columns_o,
  output logic                         last_of_run_o
);
  import icp_pkg::*;

  // count width holds MAX_ITEMS itself, index width addresses the stores
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IW = $clog2(MAX_ITEMS);

  icp_state_e state_q, state_d;

  // day and cluster bookkeeping
  logic [CW-1:0]     items_seen_q, items_seen_d;
  logic [CW-1:0]     cols_q, cols_d;
  logic [TIME_W-1:0] latest_q, latest_d;
  logic [IW-1:0]     first_q, first_d;

  // sequencer working registers
  logic [CW-1:0]     k_q, k_d;     // emit pointer
  logic [CW-1:0]     j_q, j_d;     // search pointer
  logic [IW-1:0]     col_q, col_d; // chosen column
  logic              grow_q, grow_d;
  logic              newcl_q, newcl_d;
  logic              flush_q, flush_d;
  logic              runlast_q, runlast_d;

  // latched input beat
  logic [TIME_W-1:0] s_q, s_d;
  logic [TIME_W-1:0] e_q, e_d;
  logic              fin_q, fin_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [INDEX_W-1:0]  oidx_q, oidx_d;
  logic [COLUMN_W-1:0] ocol_q, ocol_d;
  logic [CCOUNT_W-1:0] occ_q, occ_d;
  logic                olast_q, olast_d;

  // memory ports
  logic              end_we, end_re;
  logic [IW-1:0]     end_raddr;
  logic [TIME_W-1:0] end_rdata;
  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_rdata;

  // shared compare unit
  logic [TIME_W-1:0] cmp_a, cmp_b;
  logic              cmp_le;

  logic          accept;
  logic          over;
  logic          out_free;
  logic [CW-1:0] k_inc;
  logic          emit_done;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign over      = (items_seen_q == CW'(MAX_ITEMS));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign k_inc     = k_q + CW'(1);
  assign emit_done = (k_inc == items_seen_q);

  icp_ram #(
    .WIDTH(TIME_W),
    .DEPTH(MAX_ITEMS)
  ) u_end_ram (
    .clk_i  (clk_i),
    .we_i   (end_we),
    .waddr_i(col_q),
    .wdata_i(e_q),
    .re_i   (end_re),
    .raddr_i(end_raddr),
    .rdata_o(end_rdata)
  );

  icp_ram #(
    .WIDTH(IW),
    .DEPTH(MAX_ITEMS)
  ) u_member_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(items_seen_q[IW-1:0]),
    .wdata_i(col_q),
    .re_i   (mem_re),
    .raddr_i(k_q[IW-1:0]),
    .rdata_o(mem_rdata)
  );

  icp_cmp u_cmp (
    .a_i (cmp_a),
    .b_i (cmp_b),
    .le_o(cmp_le)
  );

  // operand steering for the shared compare
  always_comb begin
    case (state_q)
      ST_IDLE: begin
        cmp_a = latest_q;    // cluster closes when latest end <= start
        cmp_b = start_min_i;
      end
      ST_SRCH_CMP: begin
        cmp_a = end_rdata;   // column free when its end <= start
        cmp_b = s_q;
      end
      ST_PLACE: begin
        cmp_a = e_q;         // latest end keeps unless the new end is later or a new cluster opened
        cmp_b = latest_q;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    items_seen_d = items_seen_q;
    cols_d       = cols_q;
    latest_d     = latest_q;
    first_d      = first_q;
    k_d          = k_q;
    j_d          = j_q;
    col_d        = col_q;
    grow_d       = grow_q;
    newcl_d      = newcl_q;
    flush_d      = flush_q;
    runlast_d    = runlast_q;
    s_d          = s_q;
    e_d          = e_q;
    fin_d        = fin_q;
    oidx_d       = oidx_q;
    ocol_d       = ocol_q;
    occ_d        = occ_q;
    olast_d      = olast_q;
    out_valid_d  = out_valid_q && out_stall_i;
    end_we       = 1'b0;
    end_re       = 1'b0;
    end_raddr    = j_q[IW-1:0];
    mem_we       = 1'b0;
    mem_re       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          s_d   = start_min_i;
          e_d   = end_min_i;
          fin_d = final_item_i;
          if (over) begin
            // beyond capacity: no placement, final beat still flushes
            if (final_item_i) begin
              if (cols_q != '0) begin
                flush_d   = 1'b1;
                runlast_d = 1'b1;
                k_d       = CW'(first_q);
                state_d   = ST_EMIT_RD;
              end else begin
                items_seen_d = '0;
                cols_d       = '0;
                latest_d     = '0;
                first_d      = '0;
              end
            end
          end else begin
            newcl_d = (cols_q == '0) || cmp_le;
            if ((cols_q != '0) && cmp_le) begin
              // close the open cluster before placing
              flush_d   = 1'b0;
              runlast_d = !final_item_i;
              k_d       = CW'(first_q);
              state_d   = ST_EMIT_RD;
            end else begin
              j_d     = '0;
              state_d = ST_SRCH_RD;
            end
          end
        end
      end

      ST_EMIT_RD: begin
        mem_re  = 1'b1;
        state_d = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          oidx_d      = INDEX_W'(k_q);
          ocol_d      = COLUMN_W'(mem_rdata);
          occ_d       = CCOUNT_W'(cols_q);
          olast_d     = runlast_q && emit_done;
          k_d         = k_inc;
          if (!emit_done) begin
            state_d = ST_EMIT_RD;
          end else if (flush_q) begin
            // day over
            items_seen_d = '0;
            cols_d       = '0;
            latest_d     = '0;
            first_d      = '0;
            state_d      = ST_IDLE;
          end else begin
            // new cluster opens at this beat
            cols_d  = '0;
            first_d = items_seen_q[IW-1:0];
            j_d     = '0;
            state_d = ST_SRCH_RD;
          end
        end
      end

      ST_SRCH_RD: begin
        if (j_q == cols_q) begin
          col_d   = cols_q[IW-1:0];
          grow_d  = 1'b1;
          state_d = ST_PLACE;
        end else begin
          end_re  = 1'b1;
          state_d = ST_SRCH_CMP;
        end
      end

      ST_SRCH_CMP: begin
        if (cmp_le) begin
          col_d   = j_q[IW-1:0];
          grow_d  = 1'b0;
          state_d = ST_PLACE;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = ST_SRCH_RD;
        end
      end

      ST_PLACE: begin
        end_we       = 1'b1;
        mem_we       = 1'b1;
        items_seen_d = items_seen_q + CW'(1);
        if (grow_q) begin
          cols_d = cols_q + CW'(1);
        end
        if (newcl_q || !cmp_le) begin
          latest_d = e_q;
        end
        if (fin_q) begin
          flush_d   = 1'b1;
          runlast_d = 1'b1;
          k_d       = CW'(first_q);
          state_d   = ST_EMIT_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      items_seen_q <= '0;
      cols_q       <= '0;
      latest_q     <= '0;
      first_q      <= '0;
      k_q          <= '0;
      j_q          <= '0;
      grow_q       <= 1'b0;
      newcl_q      <= 1'b0;
      flush_q      <= 1'b0;
      runlast_q    <= 1'b0;
      fin_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      items_seen_q <= items_seen_d;
      cols_q       <= cols_d;
      latest_q     <= latest_d;
      first_q      <= first_d;
      k_q          <= k_d;
      j_q          <= j_d;
      grow_q       <= grow_d;
      newcl_q      <= newcl_d;
      flush_q      <= flush_d;
      runlast_q    <= runlast_d;
      fin_q        <= fin_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    s_q     <= s_d;
    e_q     <= e_d;
    oidx_q  <= oidx_d;
    ocol_q  <= ocol_d;
    occ_q   <= occ_d;
    olast_q <= olast_d;
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign item_index_o      = oidx_q;
  assign column_o          = ocol_q;
  assign cluster_columns_o = occ_q;
  assign last_of_run_o     = olast_q;

endmodule
